FILE: rtl/smx_pkg.sv
// ============================================================================
// SplitMix32 XOR cipher package
// Shared constants and the command item passed from front end to back end.
// ============================================================================
package smx_pkg;

    localparam logic [31:0] GOLDEN_STEP = 32'h9E37_79B9;
    localparam logic [31:0] MIX_MUL_A   = 32'h85EB_CA6B;
    localparam logic [31:0] MIX_MUL_B   = 32'hC2B2_AE35;

    localparam int SMX_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_of_string;
        logic        new_word;
        logic [1:0]  byte_pos;
        logic [31:0] gen_state;
    } smx_cmd_t;

endpackage

FILE: rtl/smx_if.sv
// ============================================================================
// SplitMix32 XOR cipher stream interfaces
// Valid/ready channels for the input byte items and the result items.
// ============================================================================
interface smx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_string;
    logic       start_of_batch;
    logic       empty_string;

    modport source (output valid, output data_byte, output last_of_string,
                    output start_of_batch, output empty_string, input ready);
    modport sink   (input valid, input data_byte, input last_of_string,
                    input start_of_batch, input empty_string, output ready);
endinterface

interface smx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       last_out;

    modport source (output valid, output cipher_byte, output last_out, input ready);
    modport sink   (input valid, input cipher_byte, input last_out, output ready);
endinterface

FILE: rtl/smx_front.sv
// ============================================================================
// SplitMix32 XOR cipher front end
// Accepts items, tracks string index and generator state, issues commands.
// ============================================================================
module smx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    smx_in_if.sink            stream,
    input  logic              queue_full,
    output logic              push,
    output smx_pkg::smx_cmd_t push_cmd
);
    import smx_pkg::*;

    logic [31:0] master_seed_reg;
    logic [31:0] string_index_reg, string_index_next;
    logic [31:0] gen_state_reg, gen_state_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic        at_start_reg, at_start_next;
    logic        accept;

    assign stream.ready = !queue_full;
    assign accept       = stream.valid && !queue_full;
    assign push         = accept && !stream.empty_string;

    always_comb
    begin
        logic [31:0] idx0;
        logic        start0;
        logic [1:0]  pos0;
        logic [1:0]  pos1;
        logic [31:0] gs;

        idx0   = stream.start_of_batch ? 32'd0 : string_index_reg;
        start0 = stream.start_of_batch || at_start_reg;
        pos0   = stream.start_of_batch ? 2'd0 : byte_pos_reg;
        pos1   = start0 ? 2'd0 : pos0;
        gs     = start0 ? (master_seed_reg ^ idx0) : gen_state_reg;
        if (pos1 == 2'd0)
        begin
            gs = gs + GOLDEN_STEP;
        end

        push_cmd.data_byte      = stream.data_byte;
        push_cmd.last_of_string = stream.last_of_string;
        push_cmd.new_word       = (pos1 == 2'd0);
        push_cmd.byte_pos       = pos1;
        push_cmd.gen_state      = gs;

        string_index_next = string_index_reg;
        gen_state_next    = gen_state_reg;
        byte_pos_next     = byte_pos_reg;
        at_start_next     = at_start_reg;

        if (stream.empty_string)
        begin
            string_index_next = idx0 + (start0 ? 32'd1 : 32'd2);
            at_start_next     = 1'b1;
            byte_pos_next     = 2'd0;
        end
        else if (stream.last_of_string)
        begin
            string_index_next = idx0 + 32'd1;
            gen_state_next    = gs;
            at_start_next     = 1'b1;
            byte_pos_next     = 2'd0;
        end
        else
        begin
            string_index_next = idx0;
            gen_state_next    = gs;
            at_start_next     = 1'b0;
            byte_pos_next     = pos1 + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_seed_reg  <= 32'd0;
            string_index_reg <= 32'd0;
            gen_state_reg    <= 32'd0;
            byte_pos_reg     <= 2'd0;
            at_start_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                master_seed_reg <= cfg_wdata;
            end
            if (accept)
            begin
                string_index_reg <= string_index_next;
                gen_state_reg    <= gen_state_next;
                byte_pos_reg     <= byte_pos_next;
                at_start_reg     <= at_start_next;
            end
        end
    end

endmodule

FILE: rtl/smx_queue.sv
// ============================================================================
// SplitMix32 XOR cipher command queue
// Small FIFO that decouples the front end from the back end.
// ============================================================================
module smx_queue #(
    parameter int DEPTH = smx_pkg::SMX_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  smx_pkg::smx_cmd_t push_cmd,
    input  logic              pop,
    output smx_pkg::smx_cmd_t pop_cmd,
    output logic              full,
    output logic              empty
);
    import smx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    smx_cmd_t         slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == CNT_W'(0));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/smx_back.sv
// ============================================================================
// SplitMix32 XOR cipher back end
// Mixes key words in the MUL2 and FIN states and XORs bytes into the result register.
// ============================================================================
module smx_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  smx_pkg::smx_cmd_t pop_cmd,
    output logic              pop,
    smx_out_if.source         result
);
    import smx_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL2 = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]  state_reg;
    logic [31:0] prod_reg;
    logic [31:0] key_word_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [1:0]  pos_reg;
    logic        out_valid_reg;
    logic [7:0]  cipher_byte_reg;
    logic        last_out_reg;
    logic [7:0]  key_byte;
    logic        slot_free;
    logic        emit;

    assign slot_free          = !out_valid_reg || result.ready;
    assign pop                = (state_reg == S_IDLE) && !queue_empty;
    assign emit               = (state_reg == S_EMIT) && slot_free;
    assign result.valid       = out_valid_reg;
    assign result.cipher_byte = cipher_byte_reg;
    assign result.last_out    = last_out_reg;

    always_comb
    begin
        unique case (pos_reg)
            2'd0: key_byte = key_word_reg[7:0];
            2'd1: key_byte = key_word_reg[15:8];
            2'd2: key_byte = key_word_reg[23:16];
            2'd3: key_byte = key_word_reg[31:24];
            default: key_byte = key_word_reg[7:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= pop_cmd.data_byte;
            last_reg <= pop_cmd.last_of_string;
            pos_reg  <= pop_cmd.byte_pos;
            prod_reg <= (pop_cmd.gen_state ^ (pop_cmd.gen_state >> 16)) * MIX_MUL_A;
        end
        else if (state_reg == S_MUL2)
        begin
            prod_reg <= (prod_reg ^ (prod_reg >> 13)) * MIX_MUL_B;
        end
        if (emit)
        begin
            cipher_byte_reg <= data_reg ^ key_byte;
            last_out_reg    <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_word_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= pop_cmd.new_word ? S_MUL2 : S_EMIT;
                    end
                end
                S_MUL2:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    key_word_reg <= prod_reg ^ (prod_reg >> 16);
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/splitmix_xor_string_cipher.sv
// ============================================================================
// SplitMix32 XOR keystream string cipher
// Accepted input items go through the command queue to the back end, where a
// byte that opens a new key word passes the MUL2 and FIN states before the
// result register. The back end pops no new item until its byte is emitted.
// Empty-string items stop in the front end. Reset is asynchronous.
// ============================================================================
module splitmix_xor_string_cipher #(
    parameter int QUEUE_DEPTH = smx_pkg::SMX_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    smx_in_if.sink      stream,
    smx_out_if.source   result
);
    import smx_pkg::*;

    smx_cmd_t push_cmd;
    smx_cmd_t pop_cmd;
    logic     push;
    logic     pop;
    logic     queue_full;
    logic     queue_empty;

    smx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .stream     (stream),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    smx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    smx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .result      (result)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SplitMix32 XOR string cipher testbench
// Streams byte items through the cipher with random idling on both channels.
// A keystream predictor works out each expected result byte and a checker
// compares every result item with it. The batch key is changed between
// phases, including its extreme values and in the middle of an open string.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_LIMIT  = 1000;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last_out;
    } cipher_byte_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    smx_in_if  in_ch ();
    smx_out_if out_ch ();

    splitmix_xor_string_cipher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stream    (in_ch),
        .result    (out_ch)
    );

    logic [31:0]  batch_key;
    logic [31:0]  string_number;
    logic [31:0]  gen_counter;
    logic [31:0]  key_word;
    logic [1:0]   key_byte_pos;
    logic         string_open;
    cipher_byte_t pending_bytes[$];
    cipher_byte_t oldest_byte;

    bit idling;
    int stall_left;
    int error_count;
    int items_sent;
    int bytes_checked;
    int keys_written;
    int quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] mix_key(input logic [31:0] z);
        logic [31:0] m;
        m = z ^ (z >> 16);
        m = m * smx_pkg::MIX_MUL_A;
        m = m ^ (m >> 13);
        m = m * smx_pkg::MIX_MUL_B;
        m = m ^ (m >> 16);
        return m;
    endfunction

    function automatic void advance_keystream(input logic [7:0] data, input logic last,
                                              input logic batch, input logic empty);
        cipher_byte_t predicted;
        if (batch)
        begin
            string_number = '0;
            string_open   = 1'b0;
            key_byte_pos  = '0;
        end
        if (empty)
        begin
            if (string_open)
                string_number = string_number + 1;
            string_number = string_number + 1;
            string_open   = 1'b0;
            key_byte_pos  = '0;
            return;
        end
        if (!string_open)
        begin
            gen_counter  = batch_key ^ string_number;
            key_byte_pos = '0;
            string_open  = 1'b1;
        end
        if (key_byte_pos == 2'd0)
        begin
            gen_counter = gen_counter + smx_pkg::GOLDEN_STEP;
            key_word    = mix_key(gen_counter);
        end
        predicted.cipher_byte = data ^ key_word[key_byte_pos * 8 +: 8];
        predicted.last_out    = last;
        pending_bytes = {pending_bytes, predicted};
        key_byte_pos = key_byte_pos + 2'd1;
        if (last)
        begin
            string_number = string_number + 1;
            string_open   = 1'b0;
            key_byte_pos  = '0;
        end
    endfunction

    task automatic send_item(input logic [7:0] data, input logic last,
                             input logic batch, input logic empty);
        int gap;
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= data;
        in_ch.last_of_string <= last;
        in_ch.start_of_batch <= batch;
        in_ch.empty_string   <= empty;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        advance_keystream(data, last, batch, empty);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_batch_key(input logic [31:0] value);
        wait_for_drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        batch_key = value;
        keys_written++;
    endtask

    task automatic test_directed_strings();
        send_item(8'h00, 1'b1, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0, 1'b0);
        send_item(8'h3C, 1'b0, 1'b0, 1'b1);
        send_item(8'h12, 1'b0, 1'b0, 1'b0);
        send_item(8'h34, 1'b0, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0, 1'b1);
        send_item(8'h01, 1'b0, 1'b0, 1'b0);
        send_item(8'h02, 1'b0, 1'b0, 1'b0);
        send_item(8'h04, 1'b0, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b1, 1'b0);
        send_item(8'hC3, 1'b1, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_key_change_mid_string();
        set_batch_key(32'hFFFF_FFFF);
        send_item(8'h55, 1'b0, 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0, 1'b0);
        set_batch_key(32'h5A5A_C3C3);
        send_item(8'h0F, 1'b0, 1'b0, 1'b0);
        send_item(8'hF0, 1'b1, 1'b0, 1'b0);
        send_item(8'h99, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic run_strings(input int count);
        int stop_at;
        int len;
        int i;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                send_item(8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 2) == 0);
            end
            else if (pick < 4)
            begin
                len = $urandom_range(1, 5);
                for (i = 0; i < len; i++)
                    send_item(8'($urandom), 1'b0, 1'b0, 1'b0);
                send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            end
            else
            begin
                len = $urandom_range(0, 9);
                if (len == 0)
                    send_item(8'($urandom), 1'($urandom), pick == 4, 1'b1);
                for (i = 0; i < len; i++)
                    send_item(8'($urandom), i == len - 1, i == 0 && pick == 5, 1'b0);
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [31:0] key;
        int p;
        for (p = 0; p < 7; p++)
        begin
            case (p)
                0:       key = 32'h0000_0000;
                1:       key = 32'hFFFF_FFFF;
                default: key = $urandom;
            endcase
            set_batch_key(key);
            idling = (p != 3) && (p != 6);
            run_strings(133);
        end
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("Unexpected result item: cipher_byte %h, last_out %b",
                       out_ch.cipher_byte, out_ch.last_out);
                error_count++;
            end
            else
            begin
                oldest_byte = pending_bytes.pop_front();
                if (out_ch.cipher_byte !== oldest_byte.cipher_byte)
                begin
                    $error("cipher_byte: expected %h, actual %h",
                           oldest_byte.cipher_byte, out_ch.cipher_byte);
                    error_count++;
                end
                if (out_ch.last_out !== oldest_byte.last_out)
                begin
                    $error("last_out: expected %b, actual %b",
                           oldest_byte.last_out, out_ch.last_out);
                    error_count++;
                end
                bytes_checked++;
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        in_ch.last_of_string = 1'b0;
        in_ch.start_of_batch = 1'b0;
        in_ch.empty_string   = 1'b0;
        batch_key            = '0;
        string_number        = '0;
        gen_counter          = '0;
        key_word             = '0;
        key_byte_pos         = '0;
        string_open          = 1'b0;
        idling               = 1'b1;
        error_count          = 0;
        items_sent           = 0;
        bytes_checked        = 0;
        keys_written         = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_strings();
        test_key_change_mid_string();
        test_random_traffic();
        wait_for_drain();

        $display("Covered %0d input items under %0d batch keys, %0d result bytes compared.",
                 items_sent, keys_written, bytes_checked);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/smx_pkg.sv
rtl/smx_if.sv
rtl/smx_front.sv
rtl/smx_queue.sv
rtl/smx_back.sv
rtl/splitmix_xor_string_cipher.sv
test/testbench.sv
